@@ rtl/core/stks_pkg.sv @@
// Shared types, constants and key ordering functions for the streaming top-K selector.
`default_nettype none
package stks_pkg;

	localparam int KEEP_DEPTH = 16;
	localparam int MAX_EMIT   = 16;
	localparam int KEY_W      = 32;
	localparam int IDX_W      = 32;
	localparam int NUM_OUT_W  = 5;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 3;

	localparam logic [NUM_OUT_W-1:0] NUM_OUT_RST = NUM_OUT_W'(16);

	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_NUM_OUT  = 1'b0;
	localparam reg_idx_t REG_KEY_MODE = 1'b1;

	typedef enum logic {
		KEY_UNSIGNED = 1'b0,
		KEY_FLOAT    = 1'b1
	} key_mode_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t  op;
		key_mode_t key_mode;
	} cell_ctl_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] index;
	} entry_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} stks_state_t;

	function automatic logic [KEY_W-1:0] order_key(input logic [KEY_W-1:0] k,
		input key_mode_t mode);
		logic [KEY_W-1:0] kk;
		kk = k;
		if (mode == KEY_UNSIGNED) begin
			return kk;
		end
		if (kk == {1'b1, {(KEY_W-1){1'b0}}}) begin
			kk = '0;
		end
		if (kk[KEY_W-1]) begin
			return ~kk;
		end
		return kk ^ {1'b1, {(KEY_W-1){1'b0}}};
	endfunction

	// True when entry (ak, ai) is strictly better than entry (bk, bi).
	function automatic logic better(input logic [KEY_W-1:0] ak, input logic [IDX_W-1:0] ai,
		input logic [KEY_W-1:0] bk, input logic [IDX_W-1:0] bi, input key_mode_t mode);
		logic [KEY_W-1:0] oa;
		logic [KEY_W-1:0] ob;
		oa = order_key(ak, mode);
		ob = order_key(bk, mode);
		if (oa == ob) begin
			return ai < bi;
		end
		return oa > ob;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/stks_if.sv @@
// Stream interfaces for the candidate and result channels.
`default_nettype none
interface stks_in_if;
	logic                       valid;
	logic                       ready;
	logic [stks_pkg::KEY_W-1:0] item_key;
	logic [stks_pkg::IDX_W-1:0] item_index;
	logic                       batch_end;

	modport source(output valid, output item_key, output item_index, output batch_end,
		input ready);
	modport sink(input valid, input item_key, input item_index, input batch_end,
		output ready);
endinterface

interface stks_out_if;
	logic                       valid;
	logic                       ready;
	logic [stks_pkg::KEY_W-1:0] out_key;
	logic [stks_pkg::IDX_W-1:0] out_index;
	logic                       out_last;

	modport source(output valid, output out_key, output out_index, output out_last,
		input ready);
	modport sink(input valid, input out_key, input out_index, input out_last,
		output ready);
endinterface
`default_nettype wire

@@ rtl/core/stks_cell.sv @@
// One slot of the sorted insertion chain.
`default_nettype none
module stks_cell (
	input  wire                        clk,
	input  wire                        arst_n,
	input  stks_pkg::cell_ctl_t        ctl,
	input  wire [stks_pkg::KEY_W-1:0]  cand_key,
	input  wire [stks_pkg::IDX_W-1:0]  cand_index,
	input  stks_pkg::entry_t           prev_entry,
	input  wire                        prev_wins,
	input  stks_pkg::entry_t           next_entry,
	output stks_pkg::entry_t           entry,
	output logic                       wins
);
	import stks_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] index_q;

	assign entry = '{valid: valid_q, key: key_q, index: index_q};
	assign wins  = !(valid_q && better(key_q, index_q, cand_key, cand_index, ctl.key_mode));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				CELL_INSERT: begin
					if (wins) begin
						valid_q <= prev_wins ? prev_entry.valid : 1'b1;
					end
				end
				CELL_SHIFT: valid_q <= next_entry.valid;
				CELL_CLEAR: valid_q <= 1'b0;
				default:    valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (wins) begin
					key_q   <= prev_wins ? prev_entry.key : cand_key;
					index_q <= prev_wins ? prev_entry.index : cand_index;
				end
			end
			CELL_SHIFT: begin
				key_q   <= next_entry.key;
				index_q <= next_entry.index;
			end
			default: begin
				key_q   <= key_q;
				index_q <= index_q;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/stks_ctrl.sv @@
// Sequencer for insertion and batch readout, with the result output register.
`default_nettype none
module stks_ctrl (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cand_valid,
	input  wire                            cand_batch_end,
	output logic                           cand_ready,
	input  stks_pkg::entry_t               head,
	input  wire                            second_valid,
	input  wire [stks_pkg::NUM_OUT_W-1:0]  num_out,
	input  stks_pkg::key_mode_t            key_mode,
	output stks_pkg::cell_ctl_t            cell_ctl,
	stks_out_if.source                     res
);
	import stks_pkg::*;

	stks_state_t          state_q;
	stks_state_t          state_nxt;
	logic [NUM_OUT_W-1:0] cnt_q;
	logic [NUM_OUT_W-1:0] cnt_nxt;
	logic                 oval_q;
	logic [KEY_W-1:0]     okey_q;
	logic [IDX_W-1:0]     oidx_q;
	logic                 olast_q;
	logic                 cand_fire;
	logic                 take;
	logic                 none_left;
	logic                 is_last;
	logic                 load;

	assign cand_fire = cand_valid && cand_ready;
	assign take      = !oval_q || res.ready;
	assign cnt_nxt   = cnt_q + NUM_OUT_W'(1);
	assign none_left = (num_out == '0) || !head.valid;
	assign is_last   = (cnt_nxt == num_out) || (cnt_nxt == NUM_OUT_W'(MAX_EMIT)) || !second_valid;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cand_fire && cand_batch_end) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (take && (none_left || is_last)) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cand_ready       = 1'b0;
		load             = 1'b0;
		cell_ctl.op      = CELL_HOLD;
		cell_ctl.key_mode = key_mode;
		case (state_q)
			ST_IDLE: begin
				cand_ready = 1'b1;
				if (cand_valid) begin
					cell_ctl.op = CELL_INSERT;
				end
			end
			ST_EMIT: begin
				if (take) begin
					if (none_left) begin
						cell_ctl.op = CELL_CLEAR;
					end else begin
						load        = 1'b1;
						cell_ctl.op = is_last ? CELL_CLEAR : CELL_SHIFT;
					end
				end
			end
			default: cand_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			oval_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cand_fire && cand_batch_end) begin
				cnt_q <= '0;
			end else if (load) begin
				cnt_q <= cnt_nxt;
			end
			if (load) begin
				oval_q <= 1'b1;
			end else if (res.ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			okey_q  <= head.key;
			oidx_q  <= head.index;
			olast_q <= is_last;
		end
	end

	assign res.valid     = oval_q;
	assign res.out_key   = okey_q;
	assign res.out_index = oidx_q;
	assign res.out_last  = olast_q;

endmodule
`default_nettype wire

@@ rtl/core/streaming_top_k_select.sv @@
// Top level of the streaming top-K selector: register port, insertion chain and sequencer.
// A candidate beat is taken every cycle while no batch is read out, sorted into the chain
// at its accepting edge. After a batch_end beat the sequencer enters its emit state, then
// registers the first result beat; one beat follows per cycle while the sink is ready.
// Candidates wait while min(num_out, entries kept, 16) beats go out, with sink stalls.
// Reset clears every slot of the chain, sets num_out to 16 and key_mode to unsigned.
`default_nettype none
module streaming_top_k_select (
	input  wire                          clk,
	input  wire                          arst_n,
	stks_in_if.sink                      cand,
	stks_out_if.source                   res,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [stks_pkg::ADDR_W-1:0]   paddr,
	input  wire [stks_pkg::DATA_W-1:0]   pwdata,
	output logic [stks_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import stks_pkg::*;

	logic [NUM_OUT_W-1:0] num_out_q;
	key_mode_t            key_mode_q;
	reg_idx_t             reg_idx;
	cell_ctl_t            cell_ctl;
	entry_t               ent [KEEP_DEPTH];
	logic                 wins [KEEP_DEPTH];
	logic                 second_valid;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_out_q  <= NUM_OUT_RST;
			key_mode_q <= KEY_UNSIGNED;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_NUM_OUT:  num_out_q  <= pwdata[NUM_OUT_W-1:0];
				REG_KEY_MODE: key_mode_q <= key_mode_t'(pwdata[0]);
				default:      num_out_q  <= num_out_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NUM_OUT:  prdata = {{(DATA_W-NUM_OUT_W){1'b0}}, num_out_q};
			REG_KEY_MODE: prdata = {{(DATA_W-1){1'b0}}, key_mode_q};
			default:      prdata = '0;
		endcase
	end

	for (genvar i = 0; i < KEEP_DEPTH; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_w;
		if (i == 0) begin : g_first
			assign prev_e = '0;
			assign prev_w = 1'b0;
		end else begin : g_mid
			assign prev_e = ent[i-1];
			assign prev_w = wins[i-1];
		end
		if (i == KEEP_DEPTH - 1) begin : g_end
			assign next_e = '0;
		end else begin : g_nxt
			assign next_e = ent[i+1];
		end
		stks_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.cand_key   (cand.item_key),
			.cand_index (cand.item_index),
			.prev_entry (prev_e),
			.prev_wins  (prev_w),
			.next_entry (next_e),
			.entry      (ent[i]),
			.wins       (wins[i])
		);
	end

	if (KEEP_DEPTH > 1) begin : g_second
		assign second_valid = ent[1].valid;
	end else begin : g_single
		assign second_valid = 1'b0;
	end

	stks_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cand_valid     (cand.valid),
		.cand_batch_end (cand.batch_end),
		.cand_ready     (cand.ready),
		.head           (ent[0]),
		.second_valid   (second_valid),
		.num_out        (num_out_q),
		.key_mode       (key_mode_q),
		.cell_ctl       (cell_ctl),
		.res            (res)
	);

endmodule
`default_nettype wire

@@ rtl/core/stks_chk.sv @@
// Port-level checker for the streaming top-K selector and its bind to the top level.
`default_nettype none
module stks_chk (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        cand_valid,
	input wire                        cand_ready,
	input wire                        cand_batch_end,
	input wire                        res_valid,
	input wire                        res_ready,
	input wire [stks_pkg::KEY_W-1:0]  res_key,
	input wire [stks_pkg::IDX_W-1:0]  res_index,
	input wire                        res_last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_key) && $stable(res_index)
			&& $stable(res_last))
		else $error("result beat changed while stalled");

	a_batch_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cand_valid && cand_ready && cand_batch_end |=> !cand_ready)
		else $error("candidate taken right after a batch end");

	a_busy_readout: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !cand_ready)
		else $error("candidate channel open during batch readout");

endmodule

bind streaming_top_k_select stks_chk u_stks_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.cand_valid     (cand.valid),
	.cand_ready     (cand.ready),
	.cand_batch_end (cand.batch_end),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_key        (res.out_key),
	.res_index      (res.out_index),
	.res_last       (res.out_last)
);
`default_nettype wire
